[sv/elr_pkg.sv]
// Shared types and constants of the escaped line reader.
package elr_pkg;

    localparam int LINE_W = 24;
    localparam int CHAR_W = 8;

    // Line number that the first line gets after reset.
    localparam logic [LINE_W-1:0] FIRST_LINE_RESET = 24'd1;

    // Result kinds.
    localparam logic [1:0] KIND_CHAR     = 2'd0;
    localparam logic [1:0] KIND_LINE_END = 2'd1;
    localparam logic [1:0] KIND_EOF      = 2'd2;

    // Byte address of the first line number register, word index bit only.
    localparam logic REG_FIRST_LINE = 1'b0;

    // Characters with a special meaning in the text.
    localparam logic [CHAR_W-1:0] CHR_BACKSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CHR_HASH      = 8'h23;
    localparam logic [CHAR_W-1:0] CHR_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CHR_SPACE     = 8'h20;
    localparam logic [CHAR_W-1:0] CHR_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CHR_LOWER_B   = 8'h62;
    localparam logic [CHAR_W-1:0] CHR_LOWER_A   = 8'h61;
    localparam logic [CHAR_W-1:0] CHR_LOWER_F   = 8'h66;
    localparam logic [CHAR_W-1:0] CHR_LOWER_R   = 8'h72;
    localparam logic [CHAR_W-1:0] CHR_LOWER_T   = 8'h74;
    localparam logic [CHAR_W-1:0] CHR_LOWER_N   = 8'h6E;
    localparam logic [CHAR_W-1:0] CHR_LOWER_P   = 8'h70;

    // Number of digits that completes an octal escape.
    localparam logic [1:0] OCTAL_MAX_DIGITS = 2'd3;

    // One result item as it travels to the output.
    typedef struct packed {
        logic [1:0]        kind;
        logic [CHAR_W-1:0] ch;
        logic [LINE_W-1:0] line;
        logic              bad;
        logic              trunc;
        logic              last;
    } result_t;

    // Configuration write toward the decoder.
    typedef struct packed {
        logic              load;
        logic [LINE_W-1:0] value;
    } cfg_write_t;

    // Handshake between the decoder and the output buffer.
    typedef struct packed {
        logic    valid;
        result_t data;
    } push_t;

endpackage

[sv/elr_decode.sv]
// Parser state and single-pass decode of one input byte into up to two results.
module elr_decode (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          data_byte,
    input  logic                end_of_input,
    input  elr_pkg::cfg_write_t cfg,
    input  logic                buf_full,
    output elr_pkg::push_t      push
);
    import elr_pkg::*;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_CONT   = 3'd1,
        MODE_COMM   = 3'd2,
        MODE_BSL    = 3'd3,
        MODE_OCT    = 3'd4
    } mode_t;

    typedef struct packed {
        mode_t   mode;
        logic    emit;
        logic    newline;
        result_t res;
    } nstep_t;

    // Handling of one byte in normal mode.
    function automatic nstep_t normal_step(input logic [7:0] b, input logic [LINE_W-1:0] line);
        nstep_t s;
        s          = '0;
        s.mode     = MODE_NORMAL;
        s.res.line = line;
        if (b == CHR_BACKSLASH)
        begin
            s.mode = MODE_BSL;
        end
        else if (b == CHR_HASH)
        begin
            s.mode = MODE_COMM;
        end
        else if (b == CHR_NEWLINE)
        begin
            s.emit     = 1'b1;
            s.newline  = 1'b1;
            s.res.kind = KIND_LINE_END;
        end
        else
        begin
            s.emit     = 1'b1;
            s.res.kind = KIND_CHAR;
            s.res.ch   = b;
        end
        return s;
    endfunction

    // Named escape: returns the bad flag over the decoded character.
    function automatic logic [8:0] esc_map(input logic [7:0] b);
        logic [8:0] r;
        case (b)
            CHR_LOWER_B:   r = {1'b0, 8'h08};
            CHR_LOWER_A:   r = {1'b0, 8'h07};
            CHR_LOWER_F:   r = {1'b0, 8'h0C};
            CHR_LOWER_R:   r = {1'b0, 8'h0D};
            CHR_LOWER_T:   r = {1'b0, 8'h09};
            CHR_LOWER_N:   r = {1'b0, 8'h0A};
            CHR_LOWER_P:   r = {1'b0, CHR_HASH};
            CHR_BACKSLASH: r = {1'b0, CHR_BACKSLASH};
            default:       r = {1'b1, b};
        endcase
        return r;
    endfunction

    mode_t             mode_reg, mode_next;
    logic [8:0]        octal_value_reg, octal_value_next;
    logic [1:0]        octal_digits_reg, octal_digits_next;
    logic [LINE_W-1:0] current_line_reg, current_line_next;
    logic [LINE_W-1:0] newlines_reg, newlines_next;
    logic              has_chars_reg, has_chars_next;
    logic              pend_valid_reg;
    result_t           pend_reg;

    logic              accept;
    logic              is_octal;
    logic [8:0]        esc;
    logic [8:0]        oct_shift;
    logic [1:0]        oct_count;
    logic [1:0]        n_res;
    result_t           res0, res1;
    nstep_t            ns;

    assign in_stall = pend_valid_reg | buf_full;
    assign accept   = in_valid & ~in_stall;
    assign is_octal = (data_byte[7:3] == 5'b00110);
    assign esc      = esc_map(data_byte);
    assign oct_shift = {octal_value_reg[5:0], data_byte[2:0]};
    assign oct_count = octal_digits_reg + 2'd1;

    // Next parser state and the results of the byte on the input.
    always_comb
    begin
        mode_next         = mode_reg;
        octal_value_next  = octal_value_reg;
        octal_digits_next = octal_digits_reg;
        current_line_next = current_line_reg;
        newlines_next     = newlines_reg;
        has_chars_next    = has_chars_reg;
        n_res             = 2'd0;
        res0              = '0;
        res1              = '0;
        res0.line         = current_line_reg;
        res1.line         = current_line_reg;
        ns                = normal_step(data_byte, current_line_reg);

        if (end_of_input)
        begin
            // End of input drops any unfinished escape or comment.
            n_res             = 2'd1;
            res0.kind         = KIND_EOF;
            res0.line         = current_line_reg + newlines_reg;
            res0.trunc        = has_chars_reg;
            current_line_next = current_line_reg + newlines_reg;
            newlines_next     = '0;
            has_chars_next    = 1'b0;
            mode_next         = MODE_NORMAL;
            octal_value_next  = '0;
            octal_digits_next = '0;
        end
        else
        begin
            unique case (mode_reg)
                MODE_CONT:
                begin
                    if (data_byte == CHR_NEWLINE)
                    begin
                        newlines_next = newlines_reg + 24'd1;
                        mode_next     = MODE_NORMAL;
                    end
                end
                MODE_COMM:
                begin
                    if (data_byte == CHR_NEWLINE)
                    begin
                        n_res             = 2'd1;
                        res0.kind         = KIND_LINE_END;
                        current_line_next = current_line_reg + newlines_reg + 24'd1;
                        newlines_next     = '0;
                        has_chars_next    = 1'b0;
                        mode_next         = MODE_NORMAL;
                    end
                end
                MODE_BSL:
                begin
                    if (data_byte == CHR_SPACE || data_byte == CHR_TAB)
                    begin
                        mode_next = MODE_CONT;
                    end
                    else if (data_byte == CHR_NEWLINE)
                    begin
                        // Escaped newline joins the lines.
                        newlines_next = newlines_reg + 24'd1;
                        mode_next     = MODE_NORMAL;
                    end
                    else if (is_octal)
                    begin
                        mode_next         = MODE_OCT;
                        octal_digits_next = 2'd1;
                        octal_value_next  = {6'd0, data_byte[2:0]};
                    end
                    else
                    begin
                        n_res          = 2'd1;
                        res0.kind      = KIND_CHAR;
                        res0.ch        = esc[7:0];
                        res0.bad       = esc[8];
                        has_chars_next = 1'b1;
                        mode_next      = MODE_NORMAL;
                    end
                end
                MODE_OCT:
                begin
                    if (is_octal)
                    begin
                        octal_value_next  = oct_shift;
                        octal_digits_next = oct_count;
                        if (oct_count == OCTAL_MAX_DIGITS)
                        begin
                            n_res          = 2'd1;
                            res0.kind      = KIND_CHAR;
                            res0.ch        = oct_shift[7:0];
                            has_chars_next = 1'b1;
                            mode_next      = MODE_NORMAL;
                        end
                    end
                    else
                    begin
                        // The value goes out first, then the ending byte is parsed again.
                        n_res          = 2'd1;
                        res0.kind      = KIND_CHAR;
                        res0.ch        = octal_value_reg[7:0];
                        has_chars_next = 1'b1;
                        mode_next      = ns.mode;
                        if (ns.emit)
                        begin
                            n_res = 2'd2;
                            res1  = ns.res;
                        end
                        if (ns.newline)
                        begin
                            current_line_next = current_line_reg + newlines_reg + 24'd1;
                            newlines_next     = '0;
                            has_chars_next    = 1'b0;
                        end
                    end
                end
                default:
                begin
                    mode_next = ns.mode;
                    if (ns.emit)
                    begin
                        n_res = 2'd1;
                        res0  = ns.res;
                    end
                    if (ns.newline)
                    begin
                        current_line_next = current_line_reg + newlines_reg + 24'd1;
                        newlines_next     = '0;
                        has_chars_next    = 1'b0;
                    end
                    else if (ns.emit)
                    begin
                        has_chars_next = 1'b1;
                    end
                end
            endcase
        end

        // Mark the final result of this byte.
        if (n_res == 2'd1)
        begin
            res0.last = 1'b1;
        end
        if (n_res == 2'd2)
        begin
            res1.last = 1'b1;
        end
    end

    // A held second result goes before anything new.
    assign push.valid = ~buf_full & (pend_valid_reg | (accept & (n_res != 2'd0)));
    assign push.data  = pend_valid_reg ? pend_reg : res0;

    // Parser state and the holding register for a second result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_NORMAL;
            octal_value_reg  <= '0;
            octal_digits_reg <= '0;
            current_line_reg <= FIRST_LINE_RESET;
            newlines_reg     <= '0;
            has_chars_reg    <= 1'b0;
            pend_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg.load)
            begin
                current_line_reg <= cfg.value;
                newlines_reg     <= '0;
            end
            else if (accept)
            begin
                mode_reg         <= mode_next;
                octal_value_reg  <= octal_value_next;
                octal_digits_reg <= octal_digits_next;
                current_line_reg <= current_line_next;
                newlines_reg     <= newlines_next;
                has_chars_reg    <= has_chars_next;
            end

            if (accept && n_res == 2'd2)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (pend_valid_reg && !buf_full)
            begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    // The holding register carries no reset.
    always_ff @(posedge clk)
    begin
        if (accept && n_res == 2'd2)
        begin
            pend_reg <= res1;
        end
    end

    // A held second result blocks new input.
    a_pend_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> in_stall)
        else $error("input taken while a second result is held");

    // A byte with two results leaves the second one held.
    a_second_held: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && n_res == 2'd2) |=> (pend_valid_reg && $past(push.valid)))
        else $error("second result not held after a two-result byte");

    // A held result drains as soon as the buffer has room.
    a_pend_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_valid_reg && !buf_full) |=> !pend_valid_reg)
        else $error("held result did not drain");

    // Only end of input produces an end-of-input result, always alone.
    a_eof_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && push.valid && push.data.kind == KIND_EOF) |-> (end_of_input && n_res == 2'd1))
        else $error("malformed end-of-input result");

endmodule

[sv/elr_out_buf.sv]
// Output register with a skid stage between the decoder and the result channel.
module elr_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  elr_pkg::push_t   push,
    output logic             buf_full,
    output logic             out_valid,
    input  logic             out_stall,
    output elr_pkg::result_t out_data
);
    import elr_pkg::*;

    logic    out_valid_reg;
    result_t out_data_reg;
    logic    skid_valid_reg;
    result_t skid_data_reg;
    logic    out_free;

    // The output register can load when empty or when its transfer completes.
    assign out_free  = ~out_valid_reg | ~out_stall;
    assign buf_full  = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Valid flags of both stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg | push.valid;
            skid_valid_reg <= 1'b0;
        end
        else if (push.valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload of both stages.
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : push.data;
        end
        else if (push.valid)
        begin
            skid_data_reg <= push.data;
        end
    end

endmodule

[sv/escaped_line_reader.sv]
// Escaped line reader: byte-serial decoder for backslash-escaped text lines.
//
// Input channel: in_valid, in_stall, data_byte, end_of_input. One raw byte per
// transfer; end_of_input marks the end of the text and data_byte is ignored.
// Result channel: out_valid, out_stall and the result fields. Each result is a
// decoded character, a line end with its line number, or end of input with
// the truncated flag. last_of_run marks the final result of one input byte.
// A result is registered in the output register. Throughput: one byte per
// cycle while in_stall is low. A byte that ends an octal escape and is itself
// a character or a line end gives two results; the second waits in a holding
// register and the input stalls until it is taken. The decode logic runs in
// one pass from the parser state registers into the output register.
// When the receiver stalls, a skid register takes one more result, and then
// in_stall rises until the output drains; nothing is lost.
// Reset puts the parser in normal mode, sets the line number to 1 and empties
// both result stages. Writing first_line_number (byte address 0) reloads the
// line count; write it only while the block is idle.
module escaped_line_reader (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        end_of_input,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  result_kind,
    output logic [7:0]  out_char,
    output logic [23:0] line_number,
    output logic        bad_escape,
    output logic        truncated,
    output logic        last_of_run
);
    import elr_pkg::*;

    logic [LINE_W-1:0] first_line_reg;
    cfg_write_t        cfg;
    push_t             push;
    logic              buf_full;
    result_t           out_data;

    // Configuration register access.
    assign pready    = 1'b1;
    assign cfg.load  = psel & penable & pwrite & (paddr[2] == REG_FIRST_LINE);
    assign cfg.value = pwdata[LINE_W-1:0];
    assign prdata    = (paddr[2] == REG_FIRST_LINE) ? {8'd0, first_line_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_line_reg <= FIRST_LINE_RESET;
        end
        else if (cfg.load)
        begin
            first_line_reg <= cfg.value;
        end
    end

    // Parser and decode.
    elr_decode u_decode (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .end_of_input (end_of_input),
        .cfg          (cfg),
        .buf_full     (buf_full),
        .push         (push)
    );

    // Result registers.
    elr_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .buf_full  (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign result_kind = out_data.kind;
    assign out_char    = out_data.ch;
    assign line_number = out_data.line;
    assign bad_escape  = out_data.bad;
    assign truncated   = out_data.trunc;
    assign last_of_run = out_data.last;

endmodule
